FILE: src/trs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trs_pkg
// Types, constants and helpers shared by the model matrix pipeline.
// ----------------------------------------------------------------------------
package trs_pkg;

   localparam int TRIG_ITERATIONS = 16;
   localparam int NSTAGE = (TRIG_ITERATIONS < 24) ? TRIG_ITERATIONS : 24;

   localparam logic signed [33:0] CORDIC_K = 34'sd652032874;
   localparam logic signed [25:0] DEG90    = 26'sd5898240;
   localparam logic signed [25:0] DEG180   = 26'sd11796480;
   localparam logic signed [25:0] DEG270   = 26'sd17694720;
   localparam logic signed [25:0] DEG360   = 26'sd23592960;
   localparam logic signed [31:0] ONE_Q16  = 32'sd65536;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] angle_x_deg;
      logic signed [31:0] angle_y_deg;
      logic signed [31:0] angle_z_deg;
      logic signed [31:0] scale_x;
      logic signed [31:0] scale_y;
      logic signed [31:0] scale_z;
   } req_type;

   typedef struct packed {
      logic [1:0]         row_index;
      logic signed [31:0] elem_0;
      logic signed [31:0] elem_1;
      logic signed [31:0] elem_2;
      logic signed [31:0] elem_3;
      logic               last_row;
   } rsp_type;

   typedef struct packed {
      logic [2:0][31:0] pos;
      logic [2:0][31:0] scale;
   } side_type;

   typedef struct packed {
      logic [2:0][31:0] cosv;
      logic [2:0][31:0] sinv;
      side_type         side;
   } trig_type;

   typedef struct packed {
      logic [2:0][2:0][31:0] e;
      logic [2:0][31:0]      pos;
   } mat_type;

   function automatic logic [21:0] atan_deg(input int i);
      logic [21:0] v;
      case (i)
         0: v = 22'd2949120;  1: v = 22'd1740967;  2: v = 22'd919879;
         3: v = 22'd466945;   4: v = 22'd234379;   5: v = 22'd117304;
         6: v = 22'd58666;    7: v = 22'd29335;    8: v = 22'd14668;
         9: v = 22'd7334;     10: v = 22'd3667;    11: v = 22'd1833;
         12: v = 22'd917;     13: v = 22'd458;     14: v = 22'd229;
         15: v = 22'd115;     16: v = 22'd57;      17: v = 22'd29;
         18: v = 22'd14;      19: v = 22'd7;       20: v = 22'd4;
         21: v = 22'd2;       22: v = 22'd1;
         default: v = 22'd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [33:0] qmul30(input logic signed [33:0] a,
                                                 input logic signed [33:0] b);
      logic signed [67:0] p;
      p = a * b;
      return p[63:30];
   endfunction

   function automatic logic [31:0] sat32(input logic signed [35:0] v);
      logic [31:0] r;
      if (v > 36'sd2147483647) r = 32'h7fff_ffff;
      else if (v < -36'sd2147483648) r = 32'h8000_0000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

FILE: src/trs_model_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trs_model_matrix
// Pose to 4x4 model matrix T*S*Rx*Ry*Rz, returned as four row transactions.
// ----------------------------------------------------------------------------
// A pose is accepted whenever the pipeline can move; the trig pipeline
// (TRIG_ITERATIONS + 4 stages) and the matrix pipeline (5 stages) take one
// pose per cycle unless a finished matrix waits on the output stage. The output
// stage sends one row per cycle while rsp_ready is high, so the sustained
// pose rate is set by the four row transactions on the response channel.
module trs_model_matrix (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  trs_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output trs_pkg::rsp_type  rsp_data
);
   import trs_pkg::*;

   logic     en;
   logic     trig_valid, rot_valid, take;
   trig_type trig_data;
   mat_type  mat_data;

   assign en        = !rot_valid || take;
   assign req_ready = en;

   trs_trig u_trig (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (trig_valid),
      .out_data  (trig_data)
   );

   trs_rot u_rot (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (trig_valid),
      .in_data   (trig_data),
      .out_valid (rot_valid),
      .out_data  (mat_data)
   );

   trs_row_ser u_ser (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rot_valid),
      .in_data   (mat_data),
      .take      (take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: src/trs_trig.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trs_trig
// Angle reduction and pipelined degree-domain CORDIC for the three axes.
// ----------------------------------------------------------------------------
module trs_trig (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  trs_pkg::req_type   in_data,
   output logic               out_valid,
   output trs_pkg::trig_type  out_data
);
   import trs_pkg::*;

   localparam int Depth = NSTAGE + 4;

   logic                v_ff    [Depth];
   side_type            side_ff [Depth];
   side_type            side_in;
   logic [2:0][31:0]    ang_in;

   logic [31:0]         ang_ff  [3];
   logic [33:0]         prod_ff [3];
   logic [33:0]         prod_in [3];
   logic [24:0]         r_ff    [3];
   logic [24:0]         r_in    [3];
   logic signed [25:0]  z_ff    [3];
   logic signed [25:0]  z_in    [3];
   logic                n_ff    [3];
   logic                n_in    [3];

   logic signed [33:0]  cx_ff [NSTAGE][3];
   logic signed [33:0]  cy_ff [NSTAGE][3];
   logic signed [25:0]  cz_ff [NSTAGE][3];
   logic                cn_ff [NSTAGE][3];

   logic [2:0][31:0]    cos_ff, sin_ff, cos_in, sin_in;

   assign ang_in  = {in_data.angle_z_deg, in_data.angle_y_deg, in_data.angle_x_deg};
   assign side_in.pos   = {in_data.pos_z, in_data.pos_y, in_data.pos_x};
   assign side_in.scale = {in_data.scale_z, in_data.scale_y, in_data.scale_x};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < Depth; s++) v_ff[s] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int s = 1; s < Depth; s++) v_ff[s] <= v_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int s = 1; s < Depth; s++) side_ff[s] <= side_ff[s-1];
      end
   end

   // floor(angle / 360 deg) from the integer degrees: biased, then reciprocal
   always_comb begin
      logic signed [17:0] dp;
      for (int k = 0; k < 3; k++) begin
         dp = $signed({{2{ang_in[k][31]}}, ang_in[k][31:16]}) + 18'sd33120;
         prod_in[k] = {17'b0, dp[16:0]} * 34'd93207;
      end
   end

   always_comb begin
      logic signed [10:0] qv;
      logic signed [19:0] qm;
      logic signed [35:0] r36;
      for (int k = 0; k < 3; k++) begin
         qv = $signed({2'b0, prod_ff[k][33:25]}) - 11'sd92;
         qm = {{9{qv[10]}}, qv} * 20'sd360;
         r36 = $signed({{4{ang_ff[k][31]}}, ang_ff[k]}) - $signed({qm, 16'b0});
         r_in[k] = r36[24:0];
      end
   end

   always_comb begin
      logic signed [25:0] r;
      for (int k = 0; k < 3; k++) begin
         r = $signed({1'b0, r_ff[k]});
         if (r <= DEG90) begin
            z_in[k] = r;
            n_in[k] = 1'b0;
         end else if (r < DEG270) begin
            z_in[k] = r - DEG180;
            n_in[k] = 1'b1;
         end else begin
            z_in[k] = r - DEG360;
            n_in[k] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            ang_ff[k]  <= ang_in[k];
            prod_ff[k] <= prod_in[k];
            r_ff[k]    <= r_in[k];
            z_ff[k]    <= z_in[k];
            n_ff[k]    <= n_in[k];
         end
      end
   end

   for (genvar s = 0; s < NSTAGE; s++) begin : g_cordic
      logic signed [33:0] xi [3];
      logic signed [33:0] yi [3];
      logic signed [25:0] zi [3];
      logic               ni [3];
      logic signed [25:0] at;

      assign at = $signed({4'b0, atan_deg(s)});

      if (s == 0) begin : g_first
         always_comb begin
            for (int k = 0; k < 3; k++) begin
               xi[k] = CORDIC_K;
               yi[k] = '0;
               zi[k] = z_ff[k];
               ni[k] = n_ff[k];
            end
         end
      end else begin : g_next
         always_comb begin
            for (int k = 0; k < 3; k++) begin
               xi[k] = cx_ff[s-1][k];
               yi[k] = cy_ff[s-1][k];
               zi[k] = cz_ff[s-1][k];
               ni[k] = cn_ff[s-1][k];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            for (int k = 0; k < 3; k++) begin
               if (zi[k] >= 0) begin
                  cx_ff[s][k] <= xi[k] - (yi[k] >>> s);
                  cy_ff[s][k] <= yi[k] + (xi[k] >>> s);
                  cz_ff[s][k] <= zi[k] - at;
               end else begin
                  cx_ff[s][k] <= xi[k] + (yi[k] >>> s);
                  cy_ff[s][k] <= yi[k] - (xi[k] >>> s);
                  cz_ff[s][k] <= zi[k] + at;
               end
               cn_ff[s][k] <= ni[k];
            end
         end
      end
   end

   always_comb begin
      logic signed [33:0] xv, yv;
      for (int k = 0; k < 3; k++) begin
         xv = cn_ff[NSTAGE-1][k] ? -cx_ff[NSTAGE-1][k] : cx_ff[NSTAGE-1][k];
         yv = cn_ff[NSTAGE-1][k] ? -cy_ff[NSTAGE-1][k] : cy_ff[NSTAGE-1][k];
         cos_in[k] = xv[31:0];
         sin_in[k] = yv[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign out_valid     = v_ff[Depth-1];
   assign out_data.cosv = cos_ff;
   assign out_data.sinv = sin_ff;
   assign out_data.side = side_ff[Depth-1];

endmodule

FILE: src/trs_rot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trs_rot
// Rotation product, per-row scaling and saturation, five register stages.
// ----------------------------------------------------------------------------
module trs_rot (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  trs_pkg::trig_type  in_data,
   output logic               out_valid,
   output trs_pkg::mat_type   out_data
);
   import trs_pkg::*;

   localparam int Depth = 5;

   logic               v_ff    [Depth];
   side_type           side_ff [Depth];

   logic signed [33:0] c [3];
   logic signed [33:0] s [3];

   // stage A
   logic signed [33:0] sxsy_ff, cxsy_ff, cycz_ff, cysz_ff, cxsz_ff;
   logic signed [33:0] cxcz_ff, sxcy_ff, sxsz_ff, sxcz_ff, cxcy_ff;
   logic signed [33:0] sy_ff, cz_ff, sz_ff;
   // stage B
   logic signed [33:0] t0_ff, t1_ff, t2_ff, t3_ff;
   logic signed [33:0] b_cycz_ff, b_cysz_ff, b_sy_ff, b_cxsz_ff, b_cxcz_ff;
   logic signed [33:0] b_sxcy_ff, b_sxsz_ff, b_sxcz_ff, b_cxcy_ff;
   // stage C, D, E
   logic signed [33:0] rot_ff [3][3];
   logic signed [35:0] sp_ff  [3][3];
   logic [2:0][2:0][31:0] e_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         c[k] = 34'($signed(in_data.cosv[k]));
         s[k] = 34'($signed(in_data.sinv[k]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Depth; i++) v_ff[i] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int i = 1; i < Depth; i++) v_ff[i] <= v_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      logic signed [65:0] p;
      if (en) begin
         side_ff[0] <= in_data.side;
         for (int i = 1; i < Depth; i++) side_ff[i] <= side_ff[i-1];

         sxsy_ff <= qmul30(s[0], s[1]);
         cxsy_ff <= qmul30(c[0], s[1]);
         cycz_ff <= qmul30(c[1], c[2]);
         cysz_ff <= qmul30(c[1], s[2]);
         cxsz_ff <= qmul30(c[0], s[2]);
         cxcz_ff <= qmul30(c[0], c[2]);
         sxcy_ff <= qmul30(s[0], c[1]);
         sxsz_ff <= qmul30(s[0], s[2]);
         sxcz_ff <= qmul30(s[0], c[2]);
         cxcy_ff <= qmul30(c[0], c[1]);
         sy_ff   <= s[1];
         cz_ff   <= c[2];
         sz_ff   <= s[2];

         t0_ff <= qmul30(sxsy_ff, cz_ff);
         t1_ff <= qmul30(sxsy_ff, sz_ff);
         t2_ff <= qmul30(cxsy_ff, cz_ff);
         t3_ff <= qmul30(cxsy_ff, sz_ff);
         b_cycz_ff <= cycz_ff;
         b_cysz_ff <= cysz_ff;
         b_sy_ff   <= sy_ff;
         b_cxsz_ff <= cxsz_ff;
         b_cxcz_ff <= cxcz_ff;
         b_sxcy_ff <= sxcy_ff;
         b_sxsz_ff <= sxsz_ff;
         b_sxcz_ff <= sxcz_ff;
         b_cxcy_ff <= cxcy_ff;

         rot_ff[0][0] <= b_cycz_ff;
         rot_ff[0][1] <= -b_cysz_ff;
         rot_ff[0][2] <= b_sy_ff;
         rot_ff[1][0] <= b_cxsz_ff + t0_ff;
         rot_ff[1][1] <= b_cxcz_ff - t1_ff;
         rot_ff[1][2] <= -b_sxcy_ff;
         rot_ff[2][0] <= b_sxsz_ff - t2_ff;
         rot_ff[2][1] <= b_sxcz_ff + t3_ff;
         rot_ff[2][2] <= b_cxcy_ff;

         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               p = 66'($signed(side_ff[2].scale[i])) * 66'(rot_ff[i][j]);
               sp_ff[i][j] <= p[65:30];
               e_ff[i][j]  <= sat32(sp_ff[i][j]);
            end
         end
      end
   end

   assign out_valid    = v_ff[Depth-1];
   assign out_data.e   = e_ff;
   assign out_data.pos = side_ff[Depth-1].pos;

endmodule

FILE: src/trs_row_ser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trs_row_ser
// Holds one finished matrix and issues it one row per transaction.
// ----------------------------------------------------------------------------
module trs_row_ser (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  trs_pkg::mat_type  in_data,
   output logic              take,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output trs_pkg::rsp_type  rsp_data
);
   import trs_pkg::*;

   logic        valid_ff;
   logic [1:0]  row_ff;
   mat_type     mat_ff;

   assign take = !valid_ff || (rsp_ready && row_ff == 2'd3);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         row_ff   <= 2'd0;
      end else if (take) begin
         valid_ff <= in_valid;
         row_ff   <= 2'd0;
      end else if (rsp_ready) begin
         row_ff <= row_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) mat_ff <= in_data;
   end

   assign rsp_valid = valid_ff;

   always_comb begin
      rsp_data.row_index = row_ff;
      rsp_data.last_row  = 1'b0;
      case (row_ff)
         2'd0, 2'd1, 2'd2: begin
            rsp_data.elem_0 = mat_ff.e[row_ff][0];
            rsp_data.elem_1 = mat_ff.e[row_ff][1];
            rsp_data.elem_2 = mat_ff.e[row_ff][2];
            rsp_data.elem_3 = mat_ff.pos[row_ff];
         end
         default: begin
            rsp_data.elem_0   = '0;
            rsp_data.elem_1   = '0;
            rsp_data.elem_2   = '0;
            rsp_data.elem_3   = ONE_Q16;
            rsp_data.last_row = 1'b1;
         end
      endcase
   end

endmodule
